### hw/rtl/unsorted_min_priority_queue_top_assert.svh
// ---------------------------------------------------------------------------
// priority queue assertion macros
// shared concurrent assertion forms for the queue block
// ---------------------------------------------------------------------------
`ifndef UNSORTED_MIN_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define UNSORTED_MIN_PRIORITY_QUEUE_TOP_ASSERT_SVH

// condition implies consequence in the same cycle
`define UPMQ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition implies consequence in the next cycle
`define UPMQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/upmq_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// priority queue package
// payload types, codes and defaults shared by the queue modules
// ---------------------------------------------------------------------------
package upmq_pkg;

   localparam int DEFAULT_CAPACITY = 16;
   localparam int VALUE_W = 32;
   localparam int STATUS_W = 2;
   localparam int OCC_W = 5;

   localparam logic ACTION_INSERT = 1'b0;
   localparam logic ACTION_DELETE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic action;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] removed_value;
      logic [STATUS_W-1:0] status;
      logic [OCC_W-1:0] occupancy;
   } rsp_type;

   typedef struct packed {
      logic insert;
      logic remove;
   } cell_ctrl_type;

endpackage

### hw/rtl/upmq_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// priority queue cell
// one slot of the sorted chain: compares against the new value and shifts
// ---------------------------------------------------------------------------
module upmq_cell
   import upmq_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int CNT_W = 5
) (
   input  logic clock,
   input  cell_ctrl_type ctrl,
   input  logic [CNT_W-1:0] count,
   input  logic signed [VALUE_W-1:0] new_value,
   input  logic signed [VALUE_W-1:0] left_value,
   input  logic left_lt,
   input  logic signed [VALUE_W-1:0] right_value,
   output logic signed [VALUE_W-1:0] value,
   output logic lt
);

   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] value_in;

   // empty slots act as plus infinity
   assign lt = (count > CNT_W'(INDEX)) ? (new_value < value_ff) : 1'b1;
   assign value = value_ff;

   always_comb begin
      value_in = value_ff;
      if (ctrl.insert) begin
         if (left_lt) begin
            value_in = left_value;
         end else if (lt) begin
            value_in = new_value;
         end
      end else if (ctrl.remove) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

### hw/rtl/unsorted_min_priority_queue_top.sv
`timescale 1ns / 1ps
// the result is registered and shown in the cycle after the transaction is taken
// throughput: one transaction per cycle unless stalled; one compare and shift per cell
// the smallest value always sits in the first cell, so a delete needs no search
// reset clears the count and the result valid; cell contents are undefined until written
// ---------------------------------------------------------------------------
// min priority queue top
// bounded min priority queue built as a sorted chain of compare and shift cells
// ---------------------------------------------------------------------------
module unsorted_min_priority_queue_top
   import upmq_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  req_type req_payload,
   output logic rsp_valid,
   input  logic rsp_stall,
   output rsp_type rsp_payload
);

`include "unsorted_min_priority_queue_top_assert.svh"

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   rsp_type rsp_payload_ff;
   rsp_type rsp_payload_in;

   logic req_accept;
   logic is_full;
   logic is_empty;
   cell_ctrl_type ctrl;
   logic [31:0] count_ext;

   logic signed [VALUE_W-1:0] cell_value [CAPACITY];
   logic cell_lt [CAPACITY];

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign is_full = (count_ff == CNT_W'(CAPACITY));
   assign is_empty = (count_ff == '0);

   assign ctrl.insert = req_accept && (req_payload.action == ACTION_INSERT) && !is_full;
   assign ctrl.remove = req_accept && (req_payload.action == ACTION_DELETE) && !is_empty;

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic signed [VALUE_W-1:0] left_v;
         logic left_l;
         logic signed [VALUE_W-1:0] right_v;
         if (gi == 0) begin : g_first
            assign left_v = req_payload.value;
            assign left_l = 1'b0;
         end else begin : g_rest
            assign left_v = cell_value[gi-1];
            assign left_l = cell_lt[gi-1];
         end
         if (gi == CAPACITY - 1) begin : g_last
            assign right_v = cell_value[gi];
         end else begin : g_inner
            assign right_v = cell_value[gi+1];
         end
         upmq_cell #(
            .INDEX(gi),
            .CNT_W(CNT_W)
         ) u_cell (
            .clock(clock),
            .ctrl(ctrl),
            .count(count_ff),
            .new_value(req_payload.value),
            .left_value(left_v),
            .left_lt(left_l),
            .right_value(right_v),
            .value(cell_value[gi]),
            .lt(cell_lt[gi])
         );
      end
   endgenerate

   always_comb begin
      count_in = count_ff;
      if (ctrl.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.remove) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign count_ext = 32'(count_in);

   always_comb begin
      rsp_payload_in = rsp_payload_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
         rsp_payload_in.removed_value = '0;
         rsp_payload_in.status = STATUS_DONE;
         rsp_payload_in.occupancy = count_ext[OCC_W-1:0];
         if (req_payload.action == ACTION_INSERT) begin
            if (is_full) begin
               rsp_payload_in.status = STATUS_FULL;
            end
         end else begin
            if (is_empty) begin
               rsp_payload_in.status = STATUS_EMPTY;
            end else begin
               rsp_payload_in.removed_value = cell_value[0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `UPMQ_ASSERT_SAME(a_count_bound, clock, reset, 1'b1,
      count_ff <= CNT_W'(CAPACITY), "count above capacity")
   `UPMQ_ASSERT_NEXT(a_insert_count, clock, reset, ctrl.insert,
      count_ff == $past(count_ff) + CNT_W'(1), "insert did not raise count")
   `UPMQ_ASSERT_NEXT(a_delete_value, clock, reset, ctrl.remove,
      rsp_payload_ff.removed_value == $past(cell_value[0]), "delete lost head value")
   `UPMQ_ASSERT_SAME(a_empty_occ, clock, reset,
      rsp_valid_ff && (rsp_payload_ff.status == STATUS_EMPTY),
      rsp_payload_ff.occupancy == '0, "empty status with nonzero occupancy")

endmodule
